// ===== rtl/core/lfl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fit package
// Shared constants, status codes and the back-to-front status group of the
// least-squares line fit block.
// ----------------------------------------------------------------------------
package lfl_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int FRAC_BITS      = 16;
	localparam int MAX_POINTS_DEF = 256;
	localparam int SLOPE_BITS     = 40;
	localparam int RES_BITS       = 33;
	localparam int LIN_BITS       = 18;
	localparam int STATUS_BITS    = 3;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 3'd0,
		ST_FEW     = 3'd1,
		ST_X_EQUAL = 3'd2,
		ST_Y_EQUAL = 3'd3,
		ST_DROPPED = 3'd4
	} fit_status_t;

	typedef struct packed {
		logic job_take;
		logic mem_busy;
	} back_stat_t;

endpackage

// ===== rtl/core/line_fit_linearity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-squares line fit with linearity
// Accumulates sample pairs and, on the final pair, fits a line and reports
// slope, intercept, largest residual, linearity and a status code.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle while a set accumulates. After the pair marked
// last, input requests are held off until the back end has taken the set and
// walked the stored pairs: setup and slope division, the intercept division,
// then the residual pass through the sample memory read port. The linearity
// division and the wait for the result to be taken overlap with the next set.
// The three divisions share one serial divider that retires one quotient bit
// per cycle.
module line_fit_linearity #(
	parameter int MAX_POINTS = lfl_pkg::MAX_POINTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] x_value,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] y_value,
	input  logic                                   last,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [lfl_pkg::SLOPE_BITS-1:0]  slope,
	output logic signed [lfl_pkg::SLOPE_BITS-1:0]  intercept,
	output logic [lfl_pkg::RES_BITS-1:0]           max_residual,
	output logic [lfl_pkg::LIN_BITS-1:0]           linearity,
	output logic [lfl_pkg::STATUS_BITS-1:0]        fit_status,
	output logic [$clog2(MAX_POINTS+1)-1:0]        point_count
);

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int SXW = lfl_pkg::SAMPLE_BITS + AW;
	localparam int PW  = 2 * lfl_pkg::SAMPLE_BITS + AW;

	lfl_pkg::back_stat_t                     stat;
	logic                                    job_valid;
	logic [CW-1:0]                           job_n;
	logic signed [SXW-1:0]                   job_sx;
	logic signed [SXW-1:0]                   job_sy;
	logic signed [PW-1:0]                    job_sxx;
	logic signed [PW-1:0]                    job_sxy;
	logic signed [lfl_pkg::SAMPLE_BITS-1:0]  job_ylo;
	logic signed [lfl_pkg::SAMPLE_BITS-1:0]  job_yhi;
	logic                                    job_ovf;
	logic [AW-1:0]                           rd_addr;
	logic signed [lfl_pkg::SAMPLE_BITS-1:0]  rd_x;
	logic signed [lfl_pkg::SAMPLE_BITS-1:0]  rd_y;
	logic [lfl_pkg::SLOPE_BITS-1:0]          slope_u;
	logic [lfl_pkg::SLOPE_BITS-1:0]          icpt_u;

	lfl_front #(
		.MAX_POINTS(MAX_POINTS),
		.AW        (AW),
		.CW        (CW),
		.SXW       (SXW),
		.PW        (PW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x_value  (x_value),
		.y_value  (y_value),
		.last     (last),
		.stat     (stat),
		.job_valid(job_valid),
		.job_n    (job_n),
		.job_sx   (job_sx),
		.job_sy   (job_sy),
		.job_sxx  (job_sxx),
		.job_sxy  (job_sxy),
		.job_ylo  (job_ylo),
		.job_yhi  (job_yhi),
		.job_ovf  (job_ovf),
		.rd_addr  (rd_addr),
		.rd_x     (rd_x),
		.rd_y     (rd_y)
	);

	lfl_back #(
		.AW        (AW),
		.CW        (CW),
		.SXW       (SXW),
		.PW        (PW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_n       (job_n),
		.job_sx      (job_sx),
		.job_sy      (job_sy),
		.job_sxx     (job_sxx),
		.job_sxy     (job_sxy),
		.job_ylo     (job_ylo),
		.job_yhi     (job_yhi),
		.job_ovf     (job_ovf),
		.stat        (stat),
		.rd_addr     (rd_addr),
		.rd_x        (rd_x),
		.rd_y        (rd_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slope       (slope_u),
		.intercept   (icpt_u),
		.max_residual(max_residual),
		.linearity   (linearity),
		.fit_status  (fit_status),
		.point_count (point_count)
	);

	assign slope     = $signed(slope_u);
	assign intercept = $signed(icpt_u);

	// The sample memory must not take new pairs while the residual pass reads it.
	a_mem_locked: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && stat.mem_busy))
		else $error("input request taken while the sample memory is being walked");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fit_status == lfl_pkg::ST_FEW) |->
		(slope == '0 && intercept == '0 && max_residual == '0 && linearity == '0))
		else $error("short set reported a nonzero fit");

	a_flat_lin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fit_status == lfl_pkg::ST_Y_EQUAL) |-> linearity == '0)
		else $error("flat set reported a nonzero linearity");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> point_count <= CW'(MAX_POINTS))
		else $error("point count exceeds the store depth");

endmodule

// ===== rtl/core/lfl_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial rounding divider
// Restoring divider, one quotient bit per cycle, giving
// floor((num + floor(den / 2)) / den).
// ----------------------------------------------------------------------------
module lfl_serial_div #(
	parameter int MW = 66,
	parameter int DW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [MW-1:0] quot
);

	localparam int CNTW = $clog2(MW + 1);

	logic [MW-1:0]   work_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic [DW:0]     rem_diff;
	logic            qbit;
	logic [DW-1:0]   rem_next;

	assign rem_sh   = {rem_q, work_q[MW-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign qbit     = rem_sh >= {1'b0, den_q};
	assign rem_next = qbit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				work_q <= num + MW'(den >> 1);
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= CNTW'(MW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= rem_next;
				work_q <= {work_q[MW-2:0], qbit};
				cnt_q  <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule

// ===== rtl/core/lfl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fit front end
// Accepts sample pairs, stores them, keeps the running sums and y range, and
// hands a snapshot of the set to the back end on the final pair.
// ----------------------------------------------------------------------------
module lfl_front #(
	parameter int MAX_POINTS = lfl_pkg::MAX_POINTS_DEF,
	parameter int AW         = 8,
	parameter int CW         = 9,
	parameter int SXW        = 24,
	parameter int PW         = 40
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] x_value,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] y_value,
	input  logic                                  last,
	input  lfl_pkg::back_stat_t                   stat,
	output logic                                  job_valid,
	output logic [CW-1:0]                         job_n,
	output logic signed [SXW-1:0]                 job_sx,
	output logic signed [SXW-1:0]                 job_sy,
	output logic signed [PW-1:0]                  job_sxx,
	output logic signed [PW-1:0]                  job_sxy,
	output logic signed [lfl_pkg::SAMPLE_BITS-1:0] job_ylo,
	output logic signed [lfl_pkg::SAMPLE_BITS-1:0] job_yhi,
	output logic                                  job_ovf,
	input  logic [AW-1:0]                         rd_addr,
	output logic signed [lfl_pkg::SAMPLE_BITS-1:0] rd_x,
	output logic signed [lfl_pkg::SAMPLE_BITS-1:0] rd_y
);

	localparam int S = lfl_pkg::SAMPLE_BITS;
	localparam logic signed [S-1:0] Y_POS = {1'b0, {(S-1){1'b1}}};
	localparam logic signed [S-1:0] Y_NEG = {1'b1, {(S-1){1'b0}}};

	logic signed [S-1:0]   x_mem [MAX_POINTS];
	logic signed [S-1:0]   y_mem [MAX_POINTS];
	logic signed [S-1:0]   rd_x_q;
	logic signed [S-1:0]   rd_y_q;

	logic [CW-1:0]         cnt_q;
	logic signed [SXW-1:0] sx_q;
	logic signed [SXW-1:0] sy_q;
	logic signed [PW-1:0]  sxx_q;
	logic signed [PW-1:0]  sxy_q;
	logic signed [S-1:0]   ylo_q;
	logic signed [S-1:0]   yhi_q;
	logic                  ovf_q;

	logic                  job_valid_q;
	logic [CW-1:0]         job_n_q;
	logic signed [SXW-1:0] job_sx_q;
	logic signed [SXW-1:0] job_sy_q;
	logic signed [PW-1:0]  job_sxx_q;
	logic signed [PW-1:0]  job_sxy_q;
	logic signed [S-1:0]   job_ylo_q;
	logic signed [S-1:0]   job_yhi_q;
	logic                  job_ovf_q;

	logic                  accept;
	logic                  room;
	logic signed [2*S-1:0] xx;
	logic signed [2*S-1:0] xy;
	logic [CW-1:0]         nxt_cnt;
	logic signed [SXW-1:0] nxt_sx;
	logic signed [SXW-1:0] nxt_sy;
	logic signed [PW-1:0]  nxt_sxx;
	logic signed [PW-1:0]  nxt_sxy;
	logic signed [S-1:0]   nxt_ylo;
	logic signed [S-1:0]   nxt_yhi;
	logic                  nxt_ovf;

	assign in_ready = !job_valid_q && !stat.mem_busy;
	assign accept   = in_valid && in_ready;
	assign room     = cnt_q < CW'(MAX_POINTS);
	assign xx       = x_value * x_value;
	assign xy       = x_value * y_value;

	always_comb begin
		nxt_cnt = cnt_q;
		nxt_sx  = sx_q;
		nxt_sy  = sy_q;
		nxt_sxx = sxx_q;
		nxt_sxy = sxy_q;
		nxt_ylo = ylo_q;
		nxt_yhi = yhi_q;
		nxt_ovf = ovf_q;
		if (room) begin
			nxt_cnt = cnt_q + CW'(1);
			nxt_sx  = sx_q + x_value;
			nxt_sy  = sy_q + y_value;
			nxt_sxx = sxx_q + xx;
			nxt_sxy = sxy_q + xy;
			if (y_value < ylo_q) begin
				nxt_ylo = y_value;
			end
			if (y_value > yhi_q) begin
				nxt_yhi = y_value;
			end
		end else begin
			nxt_ovf = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && room) begin
			x_mem[cnt_q[AW-1:0]] <= x_value;
			y_mem[cnt_q[AW-1:0]] <= y_value;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxx_q       <= '0;
			sxy_q       <= '0;
			ylo_q       <= Y_POS;
			yhi_q       <= Y_NEG;
			ovf_q       <= 1'b0;
			job_valid_q <= 1'b0;
			job_n_q     <= '0;
			job_sx_q    <= '0;
			job_sy_q    <= '0;
			job_sxx_q   <= '0;
			job_sxy_q   <= '0;
			job_ylo_q   <= '0;
			job_yhi_q   <= '0;
			job_ovf_q   <= 1'b0;
		end else begin
			if (stat.job_take) begin
				job_valid_q <= 1'b0;
			end
			if (accept) begin
				if (last) begin
					job_valid_q <= 1'b1;
					job_n_q     <= nxt_cnt;
					job_sx_q    <= nxt_sx;
					job_sy_q    <= nxt_sy;
					job_sxx_q   <= nxt_sxx;
					job_sxy_q   <= nxt_sxy;
					job_ylo_q   <= nxt_ylo;
					job_yhi_q   <= nxt_yhi;
					job_ovf_q   <= nxt_ovf;
					cnt_q       <= '0;
					sx_q        <= '0;
					sy_q        <= '0;
					sxx_q       <= '0;
					sxy_q       <= '0;
					ylo_q       <= Y_POS;
					yhi_q       <= Y_NEG;
					ovf_q       <= 1'b0;
				end else begin
					cnt_q <= nxt_cnt;
					sx_q  <= nxt_sx;
					sy_q  <= nxt_sy;
					sxx_q <= nxt_sxx;
					sxy_q <= nxt_sxy;
					ylo_q <= nxt_ylo;
					yhi_q <= nxt_yhi;
					ovf_q <= nxt_ovf;
				end
			end
		end
	end

	assign job_valid = job_valid_q;
	assign job_n     = job_n_q;
	assign job_sx    = job_sx_q;
	assign job_sy    = job_sy_q;
	assign job_sxx   = job_sxx_q;
	assign job_sxy   = job_sxy_q;
	assign job_ylo   = job_ylo_q;
	assign job_yhi   = job_yhi_q;
	assign job_ovf   = job_ovf_q;
	assign rd_x      = rd_x_q;
	assign rd_y      = rd_y_q;

endmodule

// ===== rtl/core/lfl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fit back end
// Sequencer that solves the normal equations, walks the stored pairs for the
// largest residual, forms the linearity and holds the result for delivery.
// ----------------------------------------------------------------------------
module lfl_back #(
	parameter int AW         = 8,
	parameter int CW         = 9,
	parameter int SXW        = 24,
	parameter int PW         = 40
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   job_valid,
	input  logic [CW-1:0]                          job_n,
	input  logic signed [SXW-1:0]                  job_sx,
	input  logic signed [SXW-1:0]                  job_sy,
	input  logic signed [PW-1:0]                   job_sxx,
	input  logic signed [PW-1:0]                   job_sxy,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] job_ylo,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] job_yhi,
	input  logic                                   job_ovf,
	output lfl_pkg::back_stat_t                    stat,
	output logic [AW-1:0]                          rd_addr,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] rd_x,
	input  logic signed [lfl_pkg::SAMPLE_BITS-1:0] rd_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [lfl_pkg::SLOPE_BITS-1:0]         slope,
	output logic [lfl_pkg::SLOPE_BITS-1:0]         intercept,
	output logic [lfl_pkg::RES_BITS-1:0]           max_residual,
	output logic [lfl_pkg::LIN_BITS-1:0]           linearity,
	output logic [lfl_pkg::STATUS_BITS-1:0]        fit_status,
	output logic [CW-1:0]                          point_count
);

	localparam int S  = lfl_pkg::SAMPLE_BITS;
	localparam int F  = lfl_pkg::FRAC_BITS;
	localparam int SB = lfl_pkg::SLOPE_BITS;
	localparam int RB = lfl_pkg::RES_BITS;
	localparam int LB = lfl_pkg::LIN_BITS;
	localparam int DW = PW + CW + 1;
	localparam int IW = SB + SXW;
	localparam int MW = (DW + F > IW + 1) ? DW + F : IW + 1;
	localparam int EW = SB + S + 2;

	localparam logic [MW-1:0] K_MAX   = {{(MW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic [MW-1:0] K_NEG   = K_MAX + MW'(1);
	localparam logic [MW-1:0] LIN_MAX = {{(MW-LB){1'b0}}, {LB{1'b1}}};
	localparam logic [EW-1:0] RES_MAX = {{(EW-RB){1'b0}}, {RB{1'b1}}};

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_NUM, S_CHECK, S_SDIV, S_IMUL,
		S_ISUB, S_IDIV, S_RES, S_LDIV, S_OUT
	} state_t;

	state_t                state_q;
	logic                  mem_busy_q;
	logic [CW-1:0]         n_q;
	logic signed [SXW-1:0] sx_q;
	logic signed [SXW-1:0] sy_q;
	logic signed [PW-1:0]  sxx_q;
	logic signed [PW-1:0]  sxy_q;
	logic signed [S-1:0]   ylo_q;
	logic signed [S-1:0]   yhi_q;
	logic                  ovf_q;
	logic signed [DW-1:0]  pa_q;
	logic signed [DW-1:0]  pb_q;
	logic signed [DW-1:0]  den_q;
	logic signed [DW-1:0]  num_q;
	logic signed [IW-1:0]  pi_q;
	logic                  neg_q;
	logic                  div_start_q;
	logic [MW-1:0]         div_num_q;
	logic [DW-1:0]         div_den_q;
	logic [CW-1:0]         issue_q;
	logic                  valid_s1;
	logic                  valid_s2;
	logic signed [SB+S-1:0] prod_s2;
	logic signed [S+F-1:0] yf_s2;
	logic [EW-1:0]         max_q;
	logic [SB-1:0]         slope_q;
	logic [SB-1:0]         icpt_q;
	logic [RB-1:0]         maxres_q;
	logic [LB-1:0]         lin_q;
	lfl_pkg::fit_status_t  status_q;

	logic signed [DW-1:0]  p_nxx;
	logic signed [DW-1:0]  p_sxsx;
	logic signed [DW-1:0]  p_nxy;
	logic signed [DW-1:0]  p_sxsy;
	logic signed [IW-1:0]  p_slx;
	logic signed [SB+S-1:0] p_rx;
	logic [DW-1:0]         num_mag;
	logic signed [IW:0]    t_w;
	logic [IW:0]           t_mag;
	logic signed [EW-1:0]  e_w;
	logic [EW-1:0]         e_mag;
	logic signed [S:0]     span_w;
	logic [RB-1:0]         res_sat;
	logic                  div_done;
	logic [MW-1:0]         div_quot;

	function automatic logic [SB-1:0] sat_mag(input logic [MW-1:0] q, input logic neg);
		logic [MW-1:0] k;
		k = q;
		if (neg) begin
			if (q > K_NEG) begin
				k = K_NEG;
			end
			sat_mag = -k[SB-1:0];
		end else begin
			if (q > K_MAX) begin
				k = K_MAX;
			end
			sat_mag = k[SB-1:0];
		end
	endfunction

	assign p_nxx   = $signed({1'b0, n_q}) * sxx_q;
	assign p_sxsx  = sx_q * sx_q;
	assign p_nxy   = $signed({1'b0, n_q}) * sxy_q;
	assign p_sxsy  = sx_q * sy_q;
	assign p_slx   = $signed(slope_q) * sx_q;
	assign p_rx    = $signed(slope_q) * rd_x;
	assign num_mag = num_q[DW-1] ? DW'(-num_q) : DW'(num_q);
	assign t_w     = $signed({sy_q, {F{1'b0}}}) - pi_q;
	assign t_mag   = t_w[IW] ? (IW+1)'(-t_w) : (IW+1)'(t_w);
	assign e_w     = yf_s2 - prod_s2 - $signed(icpt_q);
	assign e_mag   = e_w[EW-1] ? EW'(-e_w) : EW'(e_w);
	assign span_w  = yhi_q - ylo_q;
	assign res_sat = (max_q > RES_MAX) ? {RB{1'b1}} : max_q[RB-1:0];

	lfl_serial_div #(
		.MW(MW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mem_busy_q  <= 1'b0;
			n_q         <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxx_q       <= '0;
			sxy_q       <= '0;
			ylo_q       <= '0;
			yhi_q       <= '0;
			ovf_q       <= 1'b0;
			pa_q        <= '0;
			pb_q        <= '0;
			den_q       <= '0;
			num_q       <= '0;
			pi_q        <= '0;
			neg_q       <= 1'b0;
			div_start_q <= 1'b0;
			div_num_q   <= '0;
			div_den_q   <= '0;
			issue_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			prod_s2     <= '0;
			yf_s2       <= '0;
			max_q       <= '0;
			slope_q     <= '0;
			icpt_q      <= '0;
			maxres_q    <= '0;
			lin_q       <= '0;
			status_q    <= lfl_pkg::ST_OK;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						n_q        <= job_n;
						sx_q       <= job_sx;
						sy_q       <= job_sy;
						sxx_q      <= job_sxx;
						sxy_q      <= job_sxy;
						ylo_q      <= job_ylo;
						yhi_q      <= job_yhi;
						ovf_q      <= job_ovf;
						mem_busy_q <= 1'b1;
						state_q    <= S_MUL1;
					end
				end
				S_MUL1: begin
					pa_q    <= p_nxx;
					pb_q    <= p_sxsx;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					den_q   <= pa_q - pb_q;
					pa_q    <= p_nxy;
					pb_q    <= p_sxsy;
					state_q <= S_NUM;
				end
				S_NUM: begin
					num_q   <= pa_q - pb_q;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					slope_q  <= '0;
					icpt_q   <= '0;
					maxres_q <= '0;
					lin_q    <= '0;
					if (n_q < CW'(2)) begin
						status_q   <= lfl_pkg::ST_FEW;
						mem_busy_q <= 1'b0;
						state_q    <= S_OUT;
					end else if (den_q[DW-1] || den_q == '0) begin
						status_q   <= lfl_pkg::ST_X_EQUAL;
						mem_busy_q <= 1'b0;
						state_q    <= S_OUT;
					end else begin
						div_num_q   <= MW'({num_mag, {F{1'b0}}});
						div_den_q   <= den_q;
						neg_q       <= num_q[DW-1];
						div_start_q <= 1'b1;
						state_q     <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_done) begin
						slope_q <= sat_mag(div_quot, neg_q);
						state_q <= S_IMUL;
					end
				end
				S_IMUL: begin
					pi_q    <= p_slx;
					state_q <= S_ISUB;
				end
				S_ISUB: begin
					div_num_q   <= MW'(t_mag);
					div_den_q   <= DW'(n_q);
					neg_q       <= t_w[IW];
					div_start_q <= 1'b1;
					state_q     <= S_IDIV;
				end
				S_IDIV: begin
					if (div_done) begin
						icpt_q   <= sat_mag(div_quot, neg_q);
						issue_q  <= '0;
						valid_s1 <= 1'b0;
						valid_s2 <= 1'b0;
						max_q    <= '0;
						state_q  <= S_RES;
					end
				end
				S_RES: begin
					valid_s1 <= issue_q < n_q;
					if (issue_q < n_q) begin
						issue_q <= issue_q + CW'(1);
					end
					valid_s2 <= valid_s1;
					if (valid_s1) begin
						prod_s2 <= p_rx;
						yf_s2   <= $signed({rd_y, {F{1'b0}}});
					end
					if (valid_s2 && e_mag > max_q) begin
						max_q <= e_mag;
					end
					if (issue_q == n_q && !valid_s1 && !valid_s2) begin
						mem_busy_q <= 1'b0;
						maxres_q   <= res_sat;
						if (span_w == '0) begin
							status_q <= lfl_pkg::ST_Y_EQUAL;
							state_q  <= S_OUT;
						end else begin
							div_num_q   <= MW'(res_sat);
							div_den_q   <= DW'($unsigned(span_w));
							div_start_q <= 1'b1;
							state_q     <= S_LDIV;
						end
					end
				end
				S_LDIV: begin
					if (div_done) begin
						lin_q    <= (div_quot > LIN_MAX) ? {LB{1'b1}} : div_quot[LB-1:0];
						status_q <= ovf_q ? lfl_pkg::ST_DROPPED : lfl_pkg::ST_OK;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.job_take = (state_q == S_IDLE) && job_valid;
	assign stat.mem_busy = mem_busy_q;
	assign rd_addr       = issue_q[AW-1:0];
	assign out_valid     = state_q == S_OUT;
	assign slope         = slope_q;
	assign intercept     = icpt_q;
	assign max_residual  = maxres_q;
	assign linearity     = lin_q;
	assign fit_status    = status_q;
	assign point_count   = n_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fit testbench
// Sends sets of sample pairs to the least-squares line fit block and checks
// every result field against an in-bench fixed-point prediction. Covers the
// special cases, a full sample store, random sets and back pressure.
// ----------------------------------------------------------------------------
module tb;

	localparam int NPTS = lfl_pkg::MAX_POINTS_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SB = lfl_pkg::SLOPE_BITS;
	localparam int RB = lfl_pkg::RES_BITS;
	localparam int LB = lfl_pkg::LIN_BITS;
	localparam int FB = lfl_pkg::FRAC_BITS;

	typedef enum int {
		SET_UNIFORM,
		SET_LINE,
		SET_X_CONST,
		SET_Y_CONST
	} set_kind_t;

	typedef struct {
		logic signed [SB-1:0]         slope;
		logic signed [SB-1:0]         intercept;
		logic [RB-1:0]                max_residual;
		logic [LB-1:0]                linearity;
		lfl_pkg::fit_status_t         status;
		logic [8:0]                   count;
	} fit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_ready, last, out_valid, out_ready;
	logic signed [lfl_pkg::SAMPLE_BITS-1:0] x_value, y_value;
	logic signed [SB-1:0] slope, intercept;
	logic [RB-1:0] max_residual;
	logic [LB-1:0] linearity;
	logic [lfl_pkg::STATUS_BITS-1:0] fit_status;
	logic [8:0] point_count;

	fit_t expected_fits[$];
	int mismatches = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit no_idle = 0;
	longint cycles = 0;

	longint xs[NPTS];
	longint ys[NPTS];
	longint n_pts, sx, sy, sxx, sxy, y_lo, y_hi;
	bit dropped;

	line_fit_linearity u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_value(x_value), .y_value(y_value), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.slope(slope), .intercept(intercept), .max_residual(max_residual),
		.linearity(linearity), .fit_status(fit_status), .point_count(point_count)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint round_div(longint v, longint unsigned d);
		longint unsigned q;
		q = (magnitude(v) + d / 2) / d;
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	task automatic clear_sums();
		n_pts = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
		y_lo = 32767; y_hi = -32768; dropped = 0;
	endtask

	task automatic add_sample(longint xv, longint yv, bit lst);
		fit_t f;
		longint den, num, slp, icp, e, hi;
		longint unsigned d, a, q, r, k, lim, mres, span, lin, m;
		if (n_pts < NPTS) begin
			xs[n_pts] = xv; ys[n_pts] = yv; n_pts++;
			sx += xv; sy += yv; sxx += xv * xv; sxy += xv * yv;
			if (yv < y_lo) y_lo = yv;
			if (yv > y_hi) y_hi = yv;
		end else begin
			dropped = 1;
		end
		if (!lst) return;
		slp = 0; icp = 0; mres = 0; lin = 0;
		if (n_pts < 2) begin
			f.status = lfl_pkg::ST_FEW;
		end else begin
			den = n_pts * sxx - sx * sx;
			num = n_pts * sxy - sx * sy;
			if (den <= 0) begin
				f.status = lfl_pkg::ST_X_EQUAL;
			end else begin
				d = den; a = magnitude(num);
				q = a / d; r = a % d;
				k = (q << FB) + ((r << FB) + d / 2) / d;
				lim = (64'd1 << (SB - 1)) - 1;
				if (num < 0) begin
					if (k > lim + 1) k = lim + 1;
					slp = -longint'(k);
				end else begin
					if (k > lim) k = lim;
					slp = k;
				end
				hi = (64'sd1 << (SB - 1)) - 1;
				icp = round_div(sy * (64'sd1 << FB) - slp * sx, n_pts);
				if (icp > hi) icp = hi;
				if (icp < -hi - 1) icp = -hi - 1;
				for (int i = 0; i < n_pts; i++) begin
					e = ys[i] * (64'sd1 << FB) - (slp * xs[i] + icp);
					m = magnitude(e);
					if (m > mres) mres = m;
				end
				if (mres > (64'd1 << RB) - 1) mres = (64'd1 << RB) - 1;
				span = y_hi - y_lo;
				if (span == 0) begin
					f.status = lfl_pkg::ST_Y_EQUAL;
				end else begin
					lin = round_div(mres, span);
					if (lin > (64'd1 << LB) - 1) lin = (64'd1 << LB) - 1;
					f.status = dropped ? lfl_pkg::ST_DROPPED : lfl_pkg::ST_OK;
				end
			end
		end
		f.slope = slp[SB-1:0];
		f.intercept = icp[SB-1:0];
		f.max_residual = mres[RB-1:0];
		f.linearity = lin[LB-1:0];
		f.count = n_pts[8:0];
		expected_fits.push_back(f);
		clear_sums();
	endtask

	// Sends one request; called at a rising edge, returns at its acceptance edge.
	task automatic send_pair(longint xv, longint yv, bit lst);
		int gap;
		gap = (!no_idle && $urandom_range(5) == 0) ? $urandom_range(12, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value <= xv[15:0];
		y_value <= yv[15:0];
		last <= lst;
		do @(posedge clk); while (!in_ready);
		add_sample(xv, yv, lst);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_fits.size() != 0) @(posedge clk);
	endtask

	function automatic longint clamp16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	task automatic send_set(int len, set_kind_t kind);
		longint xv, yv, k, b, cx, cy, span;
		k = $urandom_range(64) - 32;
		b = $urandom_range(65535) - 32768;
		cx = $urandom_range(65535) - 32768;
		cy = $urandom_range(65535) - 32768;
		span = 1 << $urandom_range(15, 3);
		for (int i = 0; i < len; i++) begin
			xv = $urandom_range(65535) - 32768;
			yv = $urandom_range(65535) - 32768;
			case (kind)
				SET_LINE: begin
					xv = clamp16($urandom_range(2 * span) - span);
					yv = clamp16(k * xv + b + $urandom_range(32) - 16);
				end
				SET_X_CONST: xv = cx;
				SET_Y_CONST: yv = cy;
				default: ;
			endcase
			send_pair(xv, yv, i == len - 1);
		end
	endtask

	task automatic test_special_cases();
		send_pair(-32768, 32767, 1);
		send_pair(32767, -32768, 1);
		send_pair(-32768, -32768, 0);
		send_pair(32767, 32767, 1);
		send_pair(-32768, 0, 0);
		send_pair(32767, 5, 0);
		send_pair(0, -32768, 1);
		send_pair(100, 3, 0);
		send_pair(100, -7, 0);
		send_pair(100, 9, 1);
		send_pair(-5, 1234, 0);
		send_pair(8, 1234, 0);
		send_pair(20000, 1234, 1);
		send_pair(-32768, 32767, 0);
		send_pair(32767, -32768, 0);
		send_pair(-32768, -32768, 0);
		send_pair(32767, 32767, 1);
		send_pair(1, 2, 0);
		send_pair(2, 4, 0);
		send_pair(3, 6, 1);
		wait_drained();
	endtask

	task automatic test_store_full();
		send_set(NPTS + 3, SET_UNIFORM);
		send_set(NPTS, SET_LINE);
		wait_drained();
	endtask

	task automatic test_back_pressure();
		hold_left = 600;
		send_set(40, SET_LINE);
		send_set(5, SET_UNIFORM);
		wait_drained();
	endtask

	task automatic test_random_sets(int budget);
		int len, r;
		set_kind_t kind;
		while (budget > 0) begin
			r = $urandom_range(99);
			len = (r < 4) ? $urandom_range(NPTS + 4, 100) : $urandom_range(16, 1);
			r = $urandom_range(9);
			kind = (r < 4) ? SET_LINE : (r < 7) ? SET_UNIFORM :
				(r < 8) ? SET_X_CONST : (r < 9) ? SET_Y_CONST : SET_UNIFORM;
			send_set(len, kind);
			budget -= len;
			if ($urandom_range(15) == 0) wait_drained();
		end
	endtask

	always @(posedge clk) begin
		fit_t f;
		if (out_valid && out_ready) begin
			if (expected_fits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				f = expected_fits.pop_front();
				if (slope !== f.slope || intercept !== f.intercept ||
						max_residual !== f.max_residual || linearity !== f.linearity ||
						fit_status !== f.status || point_count !== f.count) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp k=%0d b=%0d r=%0d l=%0d s=%0d n=%0d, ",
							"got k=%0d b=%0d r=%0d l=%0d s=%0d n=%0d"},
							f.slope, f.intercept, f.max_residual, f.linearity,
							f.status, f.count, slope, intercept, max_residual,
							linearity, fit_status, point_count);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(3) == 0) begin
			stall_left = $urandom_range(12, 1) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		in_valid <= 1'b0;
		x_value <= '0;
		y_value <= '0;
		last <= 1'b0;
		out_ready <= 1'b0;
		clear_sums();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_store_full();
		test_back_pressure();
		test_random_sets(440);
		no_idle = 1;
		test_random_sets(120);
		wait_drained();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_fits.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ===== line_fit_linearity.f =====
rtl/core/lfl_pkg.sv
rtl/core/lfl_serial_div.sv
rtl/core/lfl_front.sv
rtl/core/lfl_back.sv
rtl/core/line_fit_linearity.sv
verif/tb.sv
